### rtl/tlpt_pkg.sv
// Package with constants, codes and word types of the two-level page table.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;

    localparam int TABLE_POOL        = 16;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int DIR_ENTRIES       = 1024;

    localparam int DIR_AW      = $clog2(DIR_ENTRIES);
    localparam int TBL_AW      = $clog2(ENTRIES_PER_TABLE);
    localparam int DIR_W       = $clog2(TABLE_POOL + 1);
    localparam int STORE_DEPTH = TABLE_POOL * ENTRIES_PER_TABLE;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ENTRY_W     = 32;
    localparam int FLAG_W      = 12;

    localparam logic [1:0] CMD_MAP    = 2'd0;
    localparam logic [1:0] CMD_UNMAP  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_POOL_OUT = 2'd1;
    localparam logic [1:0] STATUS_NO_TABLE = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [31:0]       virt_addr;
        logic [31:0]       phys_in;
        logic [FLAG_W-1:0] page_flags;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] phys_out;
        logic [1:0]  status;
    } t_rsp;

endpackage
`default_nettype wire

### rtl/tlpt_ram.sv
// Generic single-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/two_level_page_table_manager_core.sv
// Top level of the two-level page table: directory and table store with their control.
//
//  Channel   Ports                 Handshake
//  command   i_req, start, busy    word taken when start is high and busy is low
//  result    o_rsp, o_done         word valid for the one cycle o_done is high
//
// After reset the block clears the table store and the directory, one entry a cycle,
// over all 16384 (TABLE_POOL * ENTRIES_PER_TABLE) entries, with busy held high.
// Each command does a directory read; map and unmap then write the table store unless
// they fail, lookup reads it if a table is there. Both RAMs have a registered read.
// The result appears in the cycle after the last step; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module two_level_page_table_manager_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire tlpt_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output tlpt_pkg::t_rsp     o_rsp
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_DIR   = 2'd2;
    localparam logic [1:0] S_LOOK  = 2'd3;

    logic [1:0]                    r_state, n_state;
    tlpt_pkg::t_req                r_req, n_req;
    logic [tlpt_pkg::STORE_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic [tlpt_pkg::DIR_W-1:0]    r_used, n_used;
    logic                          r_done, n_done;
    tlpt_pkg::t_rsp                r_rsp, n_rsp;

    logic                           dir_we;
    logic [tlpt_pkg::DIR_AW-1:0]    dir_waddr;
    logic [tlpt_pkg::DIR_W-1:0]     dir_wdata;
    logic [tlpt_pkg::DIR_AW-1:0]    dir_raddr;
    logic [tlpt_pkg::DIR_W-1:0]     dir_rdata;
    logic                           st_we;
    logic [tlpt_pkg::STORE_AW-1:0]  st_waddr;
    logic [tlpt_pkg::ENTRY_W-1:0]   st_wdata;
    logic [tlpt_pkg::STORE_AW-1:0]  st_raddr;
    logic [tlpt_pkg::ENTRY_W-1:0]   st_rdata;

    logic                           dir_hit;
    logic [tlpt_pkg::DIR_W-1:0]     dir_m1;
    logic [tlpt_pkg::TBL_AW-1:0]    tbl_idx;
    logic [tlpt_pkg::STORE_AW-1:0]  hit_pos;
    logic [tlpt_pkg::STORE_AW-1:0]  new_pos;
    logic [tlpt_pkg::ENTRY_W-1:0]   map_word;

    tlpt_ram #(
        .WIDTH(tlpt_pkg::DIR_W),
        .DEPTH(tlpt_pkg::DIR_ENTRIES)
    ) u_dir_ram (
        .i_clk  (i_clk),
        .i_we   (dir_we),
        .i_waddr(dir_waddr),
        .i_wdata(dir_wdata),
        .i_raddr(dir_raddr),
        .o_rdata(dir_rdata)
    );

    tlpt_ram #(
        .WIDTH(tlpt_pkg::ENTRY_W),
        .DEPTH(tlpt_pkg::STORE_DEPTH)
    ) u_store_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_rsp     = r_rsp;
    assign dir_raddr = i_req.virt_addr[31:22];
    assign tbl_idx   = r_req.virt_addr[21:12];
    assign dir_hit   = (dir_rdata != '0) &&
                       (dir_rdata <= tlpt_pkg::DIR_W'(tlpt_pkg::TABLE_POOL));
    assign dir_m1    = dir_rdata - 1'b1;
    assign hit_pos   = tlpt_pkg::STORE_AW'({dir_m1, tbl_idx});
    assign new_pos   = tlpt_pkg::STORE_AW'({r_used, tbl_idx});
    assign map_word  = {r_req.phys_in[31:12], r_req.page_flags};
    assign st_raddr  = hit_pos;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_clr_cnt = r_clr_cnt;
        n_used    = r_used;
        n_done    = 1'b0;
        n_rsp     = '0;
        dir_we    = 1'b0;
        dir_waddr = r_req.virt_addr[31:22];
        dir_wdata = r_used + 1'b1;
        st_we     = 1'b0;
        st_waddr  = hit_pos;
        st_wdata  = map_word;
        case (r_state)
            S_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = r_clr_cnt[tlpt_pkg::DIR_AW-1:0];
                dir_wdata = '0;
                st_we     = 1'b1;
                st_waddr  = r_clr_cnt;
                st_wdata  = '0;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == tlpt_pkg::STORE_AW'(tlpt_pkg::STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_req.cmd)
                    tlpt_pkg::CMD_MAP: begin
                        if (dir_hit) begin
                            st_we = 1'b1;
                        end else if (r_used >= tlpt_pkg::DIR_W'(tlpt_pkg::TABLE_POOL)) begin
                            n_rsp.status = tlpt_pkg::STATUS_POOL_OUT;
                        end else begin
                            dir_we   = 1'b1;
                            st_we    = 1'b1;
                            st_waddr = new_pos;
                            n_used   = r_used + 1'b1;
                        end
                    end
                    tlpt_pkg::CMD_UNMAP: begin
                        if (dir_hit) begin
                            st_we    = 1'b1;
                            st_wdata = '0;
                        end else begin
                            n_rsp.status = tlpt_pkg::STATUS_NO_TABLE;
                        end
                    end
                    tlpt_pkg::CMD_LOOKUP: begin
                        if (dir_hit) begin
                            n_done  = 1'b0;
                            n_state = S_LOOK;
                        end else begin
                            n_rsp.status = tlpt_pkg::STATUS_NO_TABLE;
                        end
                    end
                    default: begin
                        n_rsp = '0;
                    end
                endcase
            end
            S_LOOK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (st_rdata != '0) begin
                    n_rsp.found    = 1'b1;
                    n_rsp.phys_out = {st_rdata[31:12], 12'h000};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_used    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_used    <= n_used;
            r_done    <= n_done;
        end
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken without raising busy");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= tlpt_pkg::DIR_W'(tlpt_pkg::TABLE_POOL))
        else $error("more tables handed out than the pool holds");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.found) |-> (o_rsp.status == tlpt_pkg::STATUS_OK))
        else $error("found reported with an error status");
`endif

endmodule
`default_nettype wire
